// ----- rtl/core/altseg_pkg.sv -----
// Shared constants for the assembly line token segmenter.
// Byte codes, scan modes, role and token class codes, field widths.
// No dependencies.
`timescale 1ns / 1ps

package altseg_pkg;

  localparam int CharW  = 8;
  localparam int RoleW  = 2;
  localparam int ClassW = 3;
  localparam int ModeW  = 2;
  localparam int UserW  = RoleW + ClassW;

  // bytes of interest
  localparam logic [CharW-1:0] ChHash   = 8'h23;  // '#'
  localparam logic [CharW-1:0] ChSpace  = 8'h20;  // ' '
  localparam logic [CharW-1:0] ChTab    = 8'h09;  // tab
  localparam logic [CharW-1:0] ChComma  = 8'h2C;  // ','
  localparam logic [CharW-1:0] ChColon  = 8'h3A;  // ':'
  localparam logic [CharW-1:0] ChLParen = 8'h28;  // '('
  localparam logic [CharW-1:0] ChRParen = 8'h29;  // ')'
  localparam logic [CharW-1:0] ChDollar = 8'h24;  // '$'
  localparam logic [CharW-1:0] ChQuote  = 8'h27;  // single quote
  localparam logic [CharW-1:0] ChBslash = 8'h5C;  // backslash

  // scan modes
  localparam logic [ModeW-1:0] MODE_NORMAL  = 2'd0;
  localparam logic [ModeW-1:0] MODE_COMMENT = 2'd1;
  localparam logic [ModeW-1:0] MODE_LITERAL = 2'd2;

  // byte roles
  localparam logic [RoleW-1:0] ROLE_DROP  = 2'd0;
  localparam logic [RoleW-1:0] ROLE_START = 2'd1;
  localparam logic [RoleW-1:0] ROLE_CONT  = 2'd2;

  // token classes
  localparam logic [ClassW-1:0] CLS_ORDINARY = 3'd0;
  localparam logic [ClassW-1:0] CLS_COMMENT  = 3'd1;
  localparam logic [ClassW-1:0] CLS_MARK     = 3'd2;
  localparam logic [ClassW-1:0] CLS_DOLLAR   = 3'd3;
  localparam logic [ClassW-1:0] CLS_LITERAL  = 3'd4;

  // scanner state carried from byte to byte
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic              esc;
    logic              tok_open;
    logic [ClassW-1:0] open_class;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    mode:       MODE_NORMAL,
    esc:        1'b0,
    tok_open:   1'b0,
    open_class: CLS_ORDINARY
  };

endpackage

// ----- rtl/core/assembly_line_token_segmenter_top.sv -----
// Assembly line token segmenter, top level.
// Labels each source byte with its role and token class; uses altseg_pkg.
`timescale 1ns / 1ps

//  channel | dir | tdata          | tuser                      | tlast
//  in_     | in  | [7:0] in_char  | -                          | line_end
//  out_    | out | [7:0] out_char | [1:0] role, [4:2] tok class | line_last
//
//  One request per cycle sustained while the output is not stalled; each byte
//  passes through the input register, then the result register.
//  The scanner state is a handful of flops updated as a byte moves from the
//  input register to the result register, so consecutive bytes chain freely.
//  rst_n is synchronous, active low: both stages empty, scanner in normal mode.
//  A stalled output holds its result; the input register still fills, and
//  in_tready drops only when both stages are full and the output is stalled.

module assembly_line_token_segmenter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [altseg_pkg::CharW-1:0]  in_tdata,   // [7:0] in_char
  input  logic                          in_tlast,   // line_end
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [altseg_pkg::CharW-1:0]  out_tdata,  // [7:0] out_char
  output logic [altseg_pkg::UserW-1:0]  out_tuser,  // [1:0] role, [4:2] token_class
  output logic                          out_tlast   // line_last
);

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                         s1_valid_r;
  logic [altseg_pkg::CharW-1:0] s1_char_r;
  logic                         s1_last_r;

  logic out_free;   // result register can take a byte this cycle
  logic s1_adv;     // byte moves from input register to result register
  logic in_acc;

  assign out_free  = !out_tvalid || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------
  // Scanner: label the byte in the input register
  // ---------------------------------------------------------------------
  altseg_pkg::scan_state_t       st_r, st_nxt, st_lbl;
  logic [altseg_pkg::RoleW-1:0]  role_nxt;
  logic [altseg_pkg::ClassW-1:0] cls_nxt;
  logic                          is_delim, is_mark;

  assign is_delim = (s1_char_r == altseg_pkg::ChSpace) ||
                    (s1_char_r == altseg_pkg::ChTab)   ||
                    (s1_char_r == altseg_pkg::ChComma);
  assign is_mark  = (s1_char_r == altseg_pkg::ChColon)  ||
                    (s1_char_r == altseg_pkg::ChLParen) ||
                    (s1_char_r == altseg_pkg::ChRParen);

  always_comb begin
    st_lbl   = st_r;
    role_nxt = altseg_pkg::ROLE_DROP;
    cls_nxt  = altseg_pkg::CLS_ORDINARY;
    unique case (st_r.mode)
      altseg_pkg::MODE_COMMENT: begin
        role_nxt = altseg_pkg::ROLE_CONT;
        cls_nxt  = altseg_pkg::CLS_COMMENT;
      end
      altseg_pkg::MODE_LITERAL: begin
        role_nxt = altseg_pkg::ROLE_CONT;
        cls_nxt  = altseg_pkg::CLS_LITERAL;
        priority if (st_r.esc) begin
          st_lbl.esc = 1'b0;
        end else if (s1_char_r == altseg_pkg::ChBslash) begin
          st_lbl.esc = 1'b1;
        end else if (s1_char_r == altseg_pkg::ChQuote) begin
          // closing quote
          st_lbl.mode       = altseg_pkg::MODE_NORMAL;
          st_lbl.tok_open   = 1'b0;
          st_lbl.open_class = altseg_pkg::CLS_ORDINARY;
        end else begin
          st_lbl.esc = 1'b0;
        end
      end
      default: begin
        // normal mode; the unused mode code behaves the same
        priority if (s1_char_r == altseg_pkg::ChHash) begin
          role_nxt          = altseg_pkg::ROLE_START;
          cls_nxt           = altseg_pkg::CLS_COMMENT;
          st_lbl.mode       = altseg_pkg::MODE_COMMENT;
          st_lbl.tok_open   = 1'b0;
          st_lbl.open_class = altseg_pkg::CLS_ORDINARY;
        end else if (is_delim) begin
          role_nxt          = altseg_pkg::ROLE_DROP;
          cls_nxt           = altseg_pkg::CLS_ORDINARY;
          st_lbl.tok_open   = 1'b0;
          st_lbl.open_class = altseg_pkg::CLS_ORDINARY;
        end else if (is_mark) begin
          role_nxt          = altseg_pkg::ROLE_START;
          cls_nxt           = altseg_pkg::CLS_MARK;
          st_lbl.tok_open   = 1'b0;
          st_lbl.open_class = altseg_pkg::CLS_ORDINARY;
        end else if (s1_char_r == altseg_pkg::ChDollar) begin
          role_nxt          = altseg_pkg::ROLE_START;
          cls_nxt           = altseg_pkg::CLS_DOLLAR;
          st_lbl.tok_open   = 1'b1;
          st_lbl.open_class = altseg_pkg::CLS_DOLLAR;
        end else if (s1_char_r == altseg_pkg::ChQuote) begin
          // opening quote is the first literal byte
          role_nxt          = altseg_pkg::ROLE_START;
          cls_nxt           = altseg_pkg::CLS_LITERAL;
          st_lbl.mode       = altseg_pkg::MODE_LITERAL;
          st_lbl.esc        = 1'b0;
          st_lbl.tok_open   = 1'b0;
          st_lbl.open_class = altseg_pkg::CLS_ORDINARY;
        end else if (st_r.tok_open) begin
          role_nxt = altseg_pkg::ROLE_CONT;
          cls_nxt  = (st_r.open_class == altseg_pkg::CLS_DOLLAR) ?
                     altseg_pkg::CLS_DOLLAR : altseg_pkg::CLS_ORDINARY;
        end else begin
          role_nxt          = altseg_pkg::ROLE_START;
          cls_nxt           = altseg_pkg::CLS_ORDINARY;
          st_lbl.tok_open   = 1'b1;
          st_lbl.open_class = altseg_pkg::CLS_ORDINARY;
        end
      end
    endcase
    // line end wipes everything after the byte is labelled
    st_nxt = s1_last_r ? altseg_pkg::ScanReset : st_lbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= altseg_pkg::ScanReset;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic                         out_valid_r;
  logic [altseg_pkg::CharW-1:0] out_char_r;
  logic [altseg_pkg::UserW-1:0] out_user_r;
  logic                         out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_char_r <= s1_char_r;
      out_user_r <= {cls_nxt, role_nxt};
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_drop_is_ordinary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[altseg_pkg::RoleW-1:0] == altseg_pkg::ROLE_DROP)
    |-> (out_tuser[altseg_pkg::UserW-1:altseg_pkg::RoleW] == altseg_pkg::CLS_ORDINARY))
    else $error("dropped byte carries a token class");

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (st_r == altseg_pkg::ScanReset))
    else $error("scanner state survived a line end");

  a_esc_only_in_literal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.esc |-> (st_r.mode == altseg_pkg::MODE_LITERAL))
    else $error("escape pending outside a literal");

  a_open_only_normal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.tok_open |-> (st_r.mode == altseg_pkg::MODE_NORMAL))
    else $error("token open while in comment or literal");

  a_cont_needs_open: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && st_r.mode == altseg_pkg::MODE_NORMAL &&
     role_nxt == altseg_pkg::ROLE_CONT) |-> st_r.tok_open)
    else $error("continuation without an open token");

endmodule
